FILE: rtl/idiv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idiv_pkg;

  // Field width on the ports.
  localparam int PORT_W = 64;

  // Working width of the division; port bits above it are ignored on input and zero on output.
  localparam int DATA_WIDTH = 64;

  // Step counter width: counts 0 .. DATA_WIDTH-1.
  localparam int COUNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture operands, form magnitudes
    logic step;  // one restoring iteration
    logic fix;   // sign fix-up into output registers
  } idiv_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/idiv_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module idiv_datapath
  import idiv_pkg::*;
(
  input  wire logic              clk,
  input  wire idiv_cmd_t         cmd,
  input  wire logic              mode,
  input  wire logic [PORT_W-1:0] dividend,
  input  wire logic [PORT_W-1:0] divisor,
  output logic      [PORT_W-1:0] quotient,
  output logic      [PORT_W-1:0] remainder,
  output logic                   divide_by_zero
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] n_in;
  logic [W-1:0] d_in;
  logic         n_neg_in;
  logic         d_neg_in;

  logic [W-1:0] acc;     // partial remainder
  logic [W-1:0] q;       // dividend magnitude shifting out, quotient shifting in
  logic [W-1:0] d;       // divisor magnitude
  logic [W-1:0] n_orig;  // dividend as given, for the zero divisor case
  logic         q_neg;
  logic         r_neg;
  logic         dz;

  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic [W-1:0] q_fix;
  logic [W-1:0] r_fix;

  assign n_in     = dividend[W-1:0];
  assign d_in     = divisor[W-1:0];
  assign n_neg_in = mode & n_in[W-1];
  assign d_neg_in = mode & d_in[W-1];

  assign shifted = {acc, q[W-1]};
  assign diff    = shifted - {1'b0, d};

  assign q_fix = dz ? {W{1'b1}} : (q_neg ? (~q + 1'b1) : q);
  assign r_fix = dz ? n_orig : (r_neg ? (~acc + 1'b1) : acc);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc    <= '0;
      q      <= n_neg_in ? (~n_in + 1'b1) : n_in;
      d      <= d_neg_in ? (~d_in + 1'b1) : d_in;
      n_orig <= n_in;
      q_neg  <= n_neg_in ^ d_neg_in;
      r_neg  <= n_neg_in;
      dz     <= (d_in == '0);
    end else if (cmd.step) begin
      if (!diff[W]) begin
        acc <= diff[W-1:0];
        q   <= {q[W-2:0], 1'b1};
      end else begin
        acc <= shifted[W-1:0];
        q   <= {q[W-2:0], 1'b0};
      end
    end
    if (cmd.fix) begin
      quotient       <= PORT_W'(q_fix);
      remainder      <= PORT_W'(r_fix);
      divide_by_zero <= dz;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/idiv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module idiv_ctrl
  import idiv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      done,
  output idiv_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIX
  } state_t;

  localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(DATA_WIDTH - 1);

  state_t             state;
  logic [COUNT_W-1:0] cnt;
  logic               accept;

  assign accept   = start & ~busy;
  assign cmd.load = accept;
  assign cmd.step = (state == S_RUN);
  assign cmd.fix  = (state == S_FIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            cnt   <= '0;
            busy  <= 1'b1;
          end
        end
        S_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_busy_tracks_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy out of step with controller state");

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIX))
    else $error("result strobe without fix-up");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_last_step_to_fix: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && cnt == LAST_STEP) |=> (state == S_FIX))
    else $error("iteration count overran");
`endif

endmodule

`default_nettype wire

FILE: rtl/int64_divider_core.sv
// Sequence: operands load on the accepting edge, restoring steps follow, then the sign fix-up raises done.
// A new request is taken only once busy falls at the fix-up; the single shared subtractor
//   decides one quotient bit per cycle.
// The receiver cannot stall: each result shows for exactly one cycle with done high.
// Reset (rst, synchronous, active high) returns the controller to idle with busy and done low.
`timescale 1ns / 1ps
`default_nettype none

module int64_divider_core
  import idiv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // request side: taken when start is high and busy is low
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              mode,
  input  wire logic [PORT_W-1:0] dividend,
  input  wire logic [PORT_W-1:0] divisor,
  // result side: valid for the one cycle that done is high
  output logic                   done,
  output logic      [PORT_W-1:0] quotient,
  output logic      [PORT_W-1:0] remainder,
  output logic                   divide_by_zero
);

  // Commands from the sequencer: load on acceptance, step for each quotient bit,
  // fix for the sign correction that also loads the result registers.
  idiv_cmd_t cmd;

  idiv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Magnitudes are divided by radix-2 restoring steps; in signed mode the quotient is
  // negated when the operand signs differ and the remainder follows the dividend sign.
  // A zero divisor yields an all-ones quotient, the dividend as remainder, and the flag.
  idiv_datapath u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .mode           (mode),
    .dividend       (dividend),
    .divisor        (divisor),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

endmodule

`default_nettype wire
